>>> sv/sha1md_pkg.sv
package sha1md_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW     = 2'd1;
  localparam logic [1:0] STATUS_AFTER_FINISH = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic [1:0]  status;
  } out_item_t;

  function automatic logic [31:0] init_chain(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] v;
    if (t < 7'd20) begin
      v = 32'h5A827999;
    end else if (t < 7'd40) begin
      v = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      v = 32'h8F1BBCDC;
    end else begin
      v = 32'hCA62C1D6;
    end
    return v;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    if (t < 7'd20) begin
      v = (b & c) | (~b & d);
    end else if (t >= 7'd40 && t < 7'd60) begin
      v = (b & c) | (b & d) | (c & d);
    end else begin
      v = b ^ c ^ d;
    end
    return v;
  endfunction

endpackage

>>> sv/sha1_message_digest.sv
// SHA-1 digest engine.
// Input channel (in_valid/in_stall/in_data): one item per operation: a message
// byte, finish, or restart. Output channel (out_valid/out_stall/out_data): five
// digest words per finish, word 0 first, the fifth marked last.
// Every 64th byte starts a compression (one read prefetch, 80 rounds at one
// per cycle, one chaining add), during which in_stall is high. The block words
// sit in a 16 x 32 memory with one write port and one read port, whose
// registered read feeds the rounds.
// Finish feeds the padding bytes one per cycle through the same byte path
// (up to 72 bytes, one or two compressions), then hands out the five words,
// one per cycle while the receiver does not stall. A stalled word holds in the
// output register and the engine waits. A finish after an error or after a
// completed digest emits at once. Reset and restart load the initial chaining
// values and clear the counters and status; the block memory is not cleared.
module sha1_message_digest (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1md_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1md_pkg::out_item_t out_data
);
  import sha1md_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_PRE  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        pad_r, pad_nxt;
  logic        first_r, first_nxt;
  logic        ok_r, ok_nxt;
  logic [63:0] len_r, len_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] chain_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] win_r [16];
  logic        out_valid_r;
  out_item_t   out_r;

  logic [31:0] mem [16];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [3:0]  mem_raddr;

  logic        in_acc;
  logic        byte_we;
  logic [7:0]  byte_val;
  logic        out_free;
  logic [31:0] w_cur, tmp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Pick the byte source: the input port or the padding sequencer
  always_comb begin
    byte_we  = 1'b0;
    byte_val = in_data.data_byte;
    if (in_acc && in_data.op == OP_BYTE && !done_r && err_r == STATUS_OK) begin
      byte_we = 1'b1;
    end else if (state_r == ST_PAD) begin
      byte_we = 1'b1;
      if (first_r) begin
        byte_val = PAD_BYTE;
      end else if (ok_r && fill_r >= 6'd56) begin
        byte_val = len_r[63:56];
      end else begin
        byte_val = 8'h00;
      end
    end
  end

  assign mem_we    = byte_we && (fill_r[1:0] == 2'b11);
  assign mem_raddr = (state_r == ST_PRE) ? 4'd0 : (rnd_r[3:0] + 4'd1);

  // Block word memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[5:2]] <= {acc_r, byte_val};
    end
    rdata_r <= mem[mem_raddr];
  end

  // Round datapath
  always_comb begin
    if (rnd_r < 7'd16) begin
      w_cur = rdata_r;
    end else begin
      w_cur = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
      w_cur = {w_cur[30:0], w_cur[31]};
    end
    tmp = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r + w_cur
          + round_k(rnd_r);
  end

  // Control sequencing
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    done_nxt  = done_r;
    err_nxt   = err_r;
    pad_nxt   = pad_r;
    first_nxt = first_r;
    ok_nxt    = ok_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;

    if (byte_we) begin
      acc_nxt  = {acc_r[15:0], byte_val};
      fill_nxt = fill_r + 6'd1;
      if (state_r == ST_PAD) begin
        if (first_r) begin
          ok_nxt = (fill_r < 6'd56);
        end else if (ok_r && fill_r >= 6'd56) begin
          len_nxt = {len_r[55:0], 8'h00};
        end
        first_nxt = 1'b0;
      end else begin
        bits_nxt = bits_r + 64'd8;
        if (bits_nxt == 64'd0) begin
          err_nxt = STATUS_OVERFLOW;
        end
      end
      if (fill_r == 6'd63) begin
        state_nxt = ST_PRE;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            OP_BYTE: begin
              if (done_r) begin
                err_nxt = STATUS_AFTER_FINISH;
              end
            end
            OP_FINISH: begin
              idx_nxt = 3'd0;
              if (err_r == STATUS_OK && !done_r) begin
                pad_nxt   = 1'b1;
                first_nxt = 1'b1;
                len_nxt   = bits_r;
                state_nxt = ST_PAD;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
            OP_RESTART: begin
              fill_nxt = 6'd0;
              bits_nxt = 64'd0;
              done_nxt = 1'b0;
              err_nxt  = STATUS_OK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAD: begin
      end
      ST_PRE: begin
        rnd_nxt   = 7'd0;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (ok_r) begin
          pad_nxt   = 1'b0;
          done_nxt  = 1'b1;
          bits_nxt  = 64'd0;
          fill_nxt  = 6'd0;
          state_nxt = ST_EMIT;
        end else begin
          ok_nxt    = 1'b1;
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd4) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= 6'd0;
      bits_r      <= 64'd0;
      done_r      <= 1'b0;
      err_r       <= STATUS_OK;
      pad_r       <= 1'b0;
      first_r     <= 1'b0;
      ok_r        <= 1'b0;
      rnd_r       <= 7'd0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      done_r  <= done_nxt;
      err_r   <= err_nxt;
      pad_r   <= pad_nxt;
      first_r <= first_nxt;
      ok_r    <= ok_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: byte assembly, length, working vars, schedule window, output
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    len_r <= len_nxt;
    if (state_r == ST_PRE) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (state_r == ST_RND) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_cur;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_r.digest_word <= (err_r != STATUS_OK) ? 32'd0 : chain_r[idx_r];
      out_r.word_index  <= idx_r;
      out_r.last        <= (idx_r == 3'd4);
      out_r.status      <= err_r;
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_data.op == OP_RESTART)) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= init_chain(3'(i));
      end
    end else if (state_r == ST_ADD) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

`ifndef SYNTH
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RND |-> rnd_r <= 7'd79)
    else $error("round counter out of range");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> out_r.word_index == 3'd4)
    else $error("last word has wrong index");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STATUS_OK |-> out_r.digest_word == 32'd0)
    else $error("digest word not zero on error");
  a_pad_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD && pad_r && ok_r |-> fill_r == 6'd0)
    else $error("final block not full");
`endif

endmodule

>>> tb/sv/sha1_message_digest_tb.sv
`timescale 1ns / 1ps

module sha1_message_digest_tb;
  import sha1md_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sha1_message_digest uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predicted hash state
  logic [31:0] chain_q [5];
  logic [7:0]  msg_block [64];
  int          fill_q;
  logic [63:0] bit_len;
  logic        digest_done;
  logic [1:0]  sticky_status;

  out_item_t digest_words_q [$];
  int        mismatch_count;
  int        cycle_count;
  bit        hold_req;
  bit        quiet_input;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sha1_message_digest: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 5; i++) chain_q[i] = init_chain(3'(i));
    fill_q = 0;
    bit_len = '0;
    digest_done = 1'b0;
    sticky_status = STATUS_OK;
  endtask

  // Run the 80 rounds over the held block
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl32(w[(t+13)&15] ^ w[(t+8)&15] ^ w[(t+2)&15] ^ w[t&15], 1);
        w[t&15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      tmp = rotl32(a, 5) + f + e + wt + k;
      e = d; d = c; c = rotl32(b, 30); b = a; a = tmp;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
    fill_q = 0;
  endtask

  // Pad with the marker byte, zeros and the bit length
  task automatic pad_message();
    int idx;
    idx = fill_q;
    msg_block[idx] = PAD_BYTE;
    idx++;
    if (idx > 56) begin
      while (idx < 64) begin msg_block[idx] = 8'h00; idx++; end
      compress_block();
      idx = 0;
    end
    while (idx < 56) begin msg_block[idx] = 8'h00; idx++; end
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    bit_len = '0;
    fill_q = 0;
    digest_done = 1'b1;
  endtask

  // Advance the predicted state by one accepted item
  task automatic predict_item(input in_item_t it);
    out_item_t r;
    case (it.op)
      OP_BYTE: begin
        if (digest_done) begin
          sticky_status = STATUS_AFTER_FINISH;
        end else if (sticky_status == STATUS_OK) begin
          msg_block[fill_q] = it.data_byte;
          fill_q++;
          bit_len += 64'd8;
          if (bit_len == '0) sticky_status = STATUS_OVERFLOW;
          if (fill_q == 64) compress_block();
        end
      end
      OP_RESTART: hash_reset();
      OP_FINISH: begin
        if (sticky_status == STATUS_OK && !digest_done) pad_message();
        for (int k = 0; k < 5; k++) begin
          r.digest_word = (sticky_status != STATUS_OK) ? 32'h0 : chain_q[k];
          r.word_index  = 3'(k);
          r.last        = (k == 4);
          r.status      = sticky_status;
          digest_words_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until accepted, then maybe idle
  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    logic stalled;
    in_item_t it;
    int gap;
    it.op = op;
    it.data_byte = data;
    in_data <= it;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    predict_item(it);
    if (quiet_input) gap = 0;
    else if ($urandom_range(0, 9) < 6) gap = 0;
    else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit twice);
    for (int i = 0; i < len; i++) send_item(OP_BYTE, 8'($urandom));
    send_item(OP_FINISH, 8'($urandom));
    if (twice) send_item(OP_FINISH, 8'($urandom));
    send_item(OP_RESTART, 8'($urandom));
  endtask

  // Receiver: random stalls, a long hold on request, check each word
  initial begin
    logic      v, s;
    out_item_t got, want;
    int        hold_left;
    int        burst_left;
    bit        stall_mode;
    hold_left = 0;
    burst_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      v = out_valid;
      s = out_stall;
      got = out_data;
      @(posedge clk);
      if (rst_n && v && !s) begin
        if (digest_words_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest word %h index %0d", got.digest_word, got.word_index);
        end else begin
          want = digest_words_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp %h idx %0d last %b st %0d, got %h idx %0d last %b st %0d",
                       want.digest_word, want.word_index, want.last, want.status,
                       got.digest_word, got.word_index, got.last, got.status);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (burst_left == 0) begin
        stall_mode = ($urandom_range(0, 2) == 0);
        burst_left = $urandom_range(10, 80);
      end else begin
        burst_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_mode) begin
        out_stall <= ($urandom_range(0, 9) < 3) || ($urandom_range(0, 49) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Extremes, every operation and the after-finish error path
  task automatic test_directed();
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hFF);
    send_item(OP_RESTART, 8'h00);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_BYTE, 8'h62);
    send_item(OP_BYTE, 8'h63);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_UNUSED, 8'hAA);
    send_item(OP_UNUSED, 8'h55);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_RESTART, 8'h00);
  endtask

  // Length field no longer fits: padding spills into a second block
  task automatic test_boundaries();
    send_message(56, $urandom_range(0, 1) == 0);
  endtask

  // Mostly short well-formed messages, some noise
  task automatic test_random_messages(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: send_item(OP_UNUSED, 8'($urandom));
          1: send_item(OP_FINISH, 8'($urandom));
          2: send_item(OP_BYTE, 8'($urandom));
          default: send_item(OP_RESTART, 8'($urandom));
        endcase
      end else begin
        send_message($urandom_range(0, 6), $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Long receiver hold with a full block of bytes offered behind it, then drain
  task automatic test_backpressure();
    quiet_input = 1;
    hold_req = 1;
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'h00);
    for (int i = 0; i < 64; i++) send_item(OP_BYTE, 8'($urandom));
    send_item(OP_FINISH, 8'h00);
    quiet_input = 0;
    in_valid <= 1'b0;
    wait (digest_words_q.size() == 0);
    @(posedge clk);
    send_item(OP_RESTART, 8'h00);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    hold_req = 0;
    quiet_input = 0;
    hash_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_boundaries();
    test_random_messages(3);
    test_backpressure();
    test_random_messages(3);

    in_valid <= 1'b0;
    wait (digest_words_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && digest_words_q.size() == 0) begin
      $display("** sha1_message_digest: PASSED **");
    end else begin
      $display("** sha1_message_digest: FAILED **");
    end
    $finish;
  end

endmodule
